// ===== rtl/base32_lenient_decoder_assert.svh =====
// Assertion macros shared by the base32 lenient decoder RTL.
`ifndef BASE32_LENIENT_DECODER_ASSERT_SVH
`define BASE32_LENIENT_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define B32D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define B32D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/b32d_pkg.sv =====
// Types and constants shared by the base32 lenient decoder modules.
package b32d_pkg;

  localparam int unsigned SymBits  = 5;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned BufBits  = 7;
  localparam int unsigned CntBits  = 3;
  localparam int unsigned AccBits  = BufBits + SymBits;

  typedef enum logic [1:0] {
    KIND_NUL,
    KIND_SPACE,
    KIND_SYM,
    KIND_BAD
  } kind_e;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DATA,
    PH_TRAIL
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_SYMBOL,
    ST_TRAIL_TEXT
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [SymBits-1:0] value;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/b32d_front.sv =====
// Front end: classifies each character and maps symbols to their 5-bit value.
module b32d_front (
  input  logic [7:0]      char_code_i,
  output b32d_pkg::item_t item_o
);

  logic [7:0] diff_upper;
  logic [7:0] diff_lower;
  logic [7:0] diff_digit;

  assign diff_upper = char_code_i - 8'h41;
  assign diff_lower = char_code_i - 8'h61;
  assign diff_digit = char_code_i - 8'h18;

  always_comb begin
    item_o.kind  = b32d_pkg::KIND_BAD;
    item_o.value = '0;
    if (char_code_i == 8'h00) begin
      item_o.kind = b32d_pkg::KIND_NUL;
    end else if (char_code_i == 8'h20 || (char_code_i >= 8'h09 && char_code_i <= 8'h0D)) begin
      item_o.kind = b32d_pkg::KIND_SPACE;
    end else if (char_code_i >= 8'h41 && char_code_i <= 8'h5A) begin
      item_o.kind  = b32d_pkg::KIND_SYM;
      item_o.value = diff_upper[b32d_pkg::SymBits-1:0];
    end else if (char_code_i >= 8'h61 && char_code_i <= 8'h7A) begin
      item_o.kind  = b32d_pkg::KIND_SYM;
      item_o.value = diff_lower[b32d_pkg::SymBits-1:0];
    end else if (char_code_i >= 8'h32 && char_code_i <= 8'h37) begin
      item_o.kind  = b32d_pkg::KIND_SYM;
      item_o.value = diff_digit[b32d_pkg::SymBits-1:0];
    end else if (char_code_i == 8'h30) begin
      item_o.kind  = b32d_pkg::KIND_SYM;
      item_o.value = 5'd14;
    end else if (char_code_i == 8'h31) begin
      item_o.kind  = b32d_pkg::KIND_SYM;
      item_o.value = 5'd11;
    end else if (char_code_i == 8'h38) begin
      item_o.kind  = b32d_pkg::KIND_SYM;
      item_o.value = 5'd1;
    end else if (char_code_i == 8'h39) begin
      item_o.kind  = b32d_pkg::KIND_SYM;
      item_o.value = 5'd6;
    end
  end

endmodule

// ===== rtl/b32d_fifo.sv =====
// Short queue of classified characters between the front and back ends.
module b32d_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  b32d_pkg::item_t       item_i,
  input  logic                  pop_i,
  output b32d_pkg::item_t       item_o,
  output b32d_pkg::fifo_stat_t  stat_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(Depth);

  b32d_pkg::item_t    mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);

endmodule

// ===== rtl/b32d_back.sv =====
// Back end: decoder state, bit packing and the registered result stage.
module b32d_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b32d_pkg::fifo_stat_t  stat_i,
  input  b32d_pkg::item_t       item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            data_byte_o,
  output logic                  byte_valid_o,
  output logic                  done_res_o,
  output b32d_pkg::status_e     status_o
);

  b32d_pkg::phase_e                 phase_q, phase_d;
  b32d_pkg::status_e                err_q, err_d;
  logic [b32d_pkg::BufBits-1:0]     buf_q, buf_d;
  logic [b32d_pkg::CntBits-1:0]     cnt_q, cnt_d;

  logic                             out_valid_q, out_valid_d;
  logic [7:0]                       data_q, data_d;
  logic                             bvalid_q, bvalid_d;
  logic                             done_q, done_d;
  b32d_pkg::status_e                status_q, status_d;

  logic [b32d_pkg::CntBits:0]       cnt_sum;
  logic [b32d_pkg::CntBits:0]       cnt_rem_w;
  logic [b32d_pkg::CntBits-1:0]     cnt_rem;
  logic [b32d_pkg::AccBits-1:0]     acc;
  logic [b32d_pkg::AccBits-1:0]     acc_shift;
  logic [b32d_pkg::BufBits-1:0]     rem_mask;
  logic                             take_sym;
  logic                             byte_full;

  assign pop_o     = !stat_i.empty && (!out_valid_q || out_ready_i);
  assign cnt_sum   = {1'b0, cnt_q} + (b32d_pkg::CntBits + 1)'(b32d_pkg::SymBits);
  assign cnt_rem_w = cnt_sum - (b32d_pkg::CntBits + 1)'(b32d_pkg::ByteBits);
  assign cnt_rem   = cnt_rem_w[b32d_pkg::CntBits-1:0];
  assign acc       = {buf_q, item_i.value};
  assign acc_shift = acc >> cnt_rem;
  assign rem_mask  = (b32d_pkg::BufBits'(1) << cnt_rem) - 1'b1;
  assign byte_full = (cnt_sum >= (b32d_pkg::CntBits + 1)'(b32d_pkg::ByteBits));
  assign take_sym  = pop_o && (item_i.kind == b32d_pkg::KIND_SYM)
                     && (err_q == b32d_pkg::ST_OK) && (phase_q != b32d_pkg::PH_TRAIL);

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    if (pop_o) begin
      unique case (item_i.kind)
        b32d_pkg::KIND_NUL: begin
          phase_d = b32d_pkg::PH_LEAD;
          err_d   = b32d_pkg::ST_OK;
          buf_d   = '0;
          cnt_d   = '0;
        end
        b32d_pkg::KIND_SPACE: begin
          if (phase_q == b32d_pkg::PH_DATA) begin
            phase_d = b32d_pkg::PH_TRAIL;
          end
        end
        b32d_pkg::KIND_SYM: begin
          if (err_q == b32d_pkg::ST_OK) begin
            if (phase_q == b32d_pkg::PH_TRAIL) begin
              err_d = b32d_pkg::ST_TRAIL_TEXT;
            end else begin
              phase_d = b32d_pkg::PH_DATA;
              if (byte_full) begin
                buf_d = acc[b32d_pkg::BufBits-1:0] & rem_mask;
                cnt_d = cnt_rem;
              end else begin
                buf_d = acc[b32d_pkg::BufBits-1:0];
                cnt_d = cnt_sum[b32d_pkg::CntBits-1:0];
              end
            end
          end
        end
        b32d_pkg::KIND_BAD: begin
          if (err_q == b32d_pkg::ST_OK) begin
            err_d = (phase_q == b32d_pkg::PH_TRAIL) ? b32d_pkg::ST_TRAIL_TEXT
                                                    : b32d_pkg::ST_BAD_SYMBOL;
          end
        end
        default: begin
          err_d = err_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    data_d      = data_q;
    bvalid_d    = bvalid_q;
    done_d      = done_q;
    status_d    = status_q;
    if (pop_o && item_i.kind == b32d_pkg::KIND_NUL) begin
      out_valid_d = 1'b1;
      data_d      = '0;
      bvalid_d    = 1'b0;
      done_d      = 1'b1;
      status_d    = err_q;
    end else if (take_sym && byte_full) begin
      out_valid_d = 1'b1;
      data_d      = acc_shift[7:0];
      bvalid_d    = 1'b1;
      done_d      = 1'b0;
      status_d    = b32d_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= b32d_pkg::PH_LEAD;
      err_q       <= b32d_pkg::ST_OK;
      buf_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      err_q       <= err_d;
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    bvalid_q <= bvalid_d;
    done_q   <= done_d;
    status_q <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = data_q;
  assign byte_valid_o = bvalid_q;
  assign done_res_o   = done_q;
  assign status_o     = status_q;

endmodule

// ===== rtl/base32_lenient_decoder.sv =====
// Top level of the lenient base32 stream decoder.
// The slave stream takes one character per request in s_axis_tdata_i; a NUL
// ends the string and re-arms the decoder for the next one.
// The master stream returns one result per completed byte or per NUL:
// tdata carries the decoded byte and the two-bit status, tuser flags a
// byte result and tlast marks the end-of-string result with its status.
// Spaces and symbols that complete no byte produce no result.
// Throughput is one character per cycle while the receiver takes results,
// set by the combinational symbol lookup in the front end and the bit packer
// in the back end. An accepted character is written into the queue register,
// and its result is then held in the output register.
// When the receiver stalls, the output register holds its result, the
// queue absorbs up to QueueDepth characters, and then s_axis_tready_o
// drops until the result is taken.
// Reset empties the queue and the output register and returns the decoder
// to its leading-whitespace state with no error latched.
module base32_lenient_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] data_byte, [9:8] status, [15:10] zero
  output logic        m_axis_tuser_o,   // [0] byte_valid
  output logic        m_axis_tlast_o    // done_res
);

  b32d_pkg::item_t      front_item;
  b32d_pkg::item_t      queue_item;
  b32d_pkg::fifo_stat_t queue_stat;
  b32d_pkg::status_e    status;
  logic                 push;
  logic                 pop;
  logic [7:0]           data_byte;

  b32d_front u_front (
    .char_code_i (s_axis_tdata_i),
    .item_o      (front_item)
  );

  assign s_axis_tready_o = !queue_stat.full;
  assign push            = s_axis_tvalid_i && !queue_stat.full;

  b32d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (queue_stat)
  );

  b32d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_i       (queue_stat),
    .item_i       (queue_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .data_byte_o  (data_byte),
    .byte_valid_o (m_axis_tuser_o),
    .done_res_o   (m_axis_tlast_o),
    .status_o     (status)
  );

  assign m_axis_tdata_o = {6'd0, status, data_byte};

`include "base32_lenient_decoder_assert.svh"

  `B32D_ASSERT_NOW(a_pop_not_empty, pop, !queue_stat.empty, "pop from an empty queue")
  `B32D_ASSERT_NOW(a_stat_excl, 1'b1, !(queue_stat.full && queue_stat.empty),
                   "queue reports full and empty")
  `B32D_ASSERT_NOW(a_result_kind, m_axis_tvalid_o, !(m_axis_tuser_o && m_axis_tlast_o),
                   "result is both a byte and an end of string")
  `B32D_ASSERT_NEXT(a_stall_no_pop, m_axis_tvalid_o && !m_axis_tready_i,
                    m_axis_tvalid_o, "stalled result dropped")

endmodule
